[src/int128_to_decimal_text_macros.svh]
// Assertion macros shared by the decimal text converter.
`ifndef INT128_TO_DECIMAL_TEXT_MACROS_SVH
`define INT128_TO_DECIMAL_TEXT_MACROS_SVH

// Same-cycle implication check.
`define I2D_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("int128_to_decimal_text: assertion failed");

// Next-cycle implication check.
`define I2D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("int128_to_decimal_text: assertion failed");

`endif

[src/i2d_pkg.sv]
// Package with types and constants of the decimal text converter.
package i2d_pkg;

  // Width of the converted value and number of BCD digit cells.
  localparam int unsigned ValueWidth = 128;
  localparam int unsigned HalfWidth  = 64;
  localparam int unsigned NumDigits  = 39;
  localparam int unsigned SignBit    = 63;

  localparam int unsigned CntWidth  = $clog2(ValueWidth);
  localparam int unsigned NdigWidth = $clog2(NumDigits + 1);

  // ASCII codes.
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } i2d_state_e;

  // Per-cycle command broadcast to every digit cell.
  typedef struct packed {
    logic clear;
    logic dabble;
    logic shift;
  } i2d_cell_ctrl_t;

endpackage

[src/int128_to_decimal_text.sv]
// After an input transfer, the value is converted by shift-and-add-3 steps through the digit cells,
// then up to 38 leading zero digits are skipped one at a time and output starts,
// then one character per cycle while the output side does not stall.
// The next transfer is taken only once the last character is loaded and the controller is back in idle.
// Reset (rst_ni, asynchronous, active low) empties the output and returns to idle.
module int128_to_decimal_text (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_high_i,
  input  logic [63:0] value_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  character_o,
  output logic        is_last_o
);
  import i2d_pkg::*;

  `include "int128_to_decimal_text_macros.svh"

  i2d_state_e state_q, state_d;
  logic [ValueWidth-1:0] mag_q, mag_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic [NdigWidth-1:0]  ndig_q, ndig_d;
  logic                  sign_pend_q, sign_pend_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;

  i2d_cell_ctrl_t        cell_ctrl;
  logic [3:0]            digit_w [NumDigits];
  logic                  carry_w [NumDigits];
  logic [3:0]            top_digit;
  logic                  in_xfer;
  logic                  slot_free;
  logic [ValueWidth-1:0] raw_value;
  logic                  raw_neg;
  logic                  conv_last;
  logic                  skip_done;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer   = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign raw_value = {value_high_i, value_low_i};
  assign raw_neg   = value_high_i[SignBit];
  assign top_digit = digit_w[NumDigits-1];
  assign conv_last = (state_q == ST_CONV) && (cnt_q == CntWidth'(ValueWidth - 1));
  assign skip_done = (state_q == ST_SKIP) && (state_d == ST_EMIT);

  // Row of digit cells; data moves from cell 0 toward the top cell.
  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    logic       bit_in;
    logic [3:0] digit_in;
    if (i == 0) begin : g_first
      assign bit_in   = mag_q[ValueWidth-1];
      assign digit_in = 4'd0;
    end else begin : g_rest
      assign bit_in   = carry_w[i-1];
      assign digit_in = digit_w[i-1];
    end
    i2d_bcd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .bit_i   (bit_in),
      .digit_i (digit_in),
      .carry_o (carry_w[i]),
      .digit_o (digit_w[i])
    );
  end

  // Next state, cell commands and output register loading.
  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    cnt_d       = cnt_q;
    ndig_d      = ndig_q;
    sign_pend_d = sign_pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    cell_ctrl   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          mag_d           = raw_neg ? (~raw_value + {{(ValueWidth-1){1'b0}}, 1'b1})
                                    : raw_value;
          sign_pend_d     = raw_neg;
          cnt_d           = '0;
          cell_ctrl.clear = 1'b1;
          state_d         = ST_CONV;
        end
      end
      ST_CONV: begin
        cell_ctrl.dabble = 1'b1;
        mag_d            = {mag_q[ValueWidth-2:0], 1'b0};
        cnt_d            = cnt_q + 1'b1;
        if (cnt_q == CntWidth'(ValueWidth - 1)) begin
          ndig_d  = NdigWidth'(NumDigits);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && ndig_q != NdigWidth'(1)) begin
          cell_ctrl.shift = 1'b1;
          ndig_d          = ndig_q - 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (sign_pend_q) begin
            char_d      = CharMinus;
            last_d      = 1'b0;
            sign_pend_d = 1'b0;
          end else begin
            char_d          = CharZero + {4'd0, top_digit};
            last_d          = (ndig_q == NdigWidth'(1));
            cell_ctrl.shift = 1'b1;
            ndig_d          = ndig_q - 1'b1;
            if (ndig_q == NdigWidth'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ndig_q      <= '0;
      sign_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ndig_q      <= ndig_d;
      sign_pend_q <= sign_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign is_last_o   = last_q;

  // The magnitude never overflows the top digit cell.
  `I2D_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, state_q == ST_CONV, !carry_w[NumDigits-1])
  // After the last conversion step the controller moves to leading zero skipping.
  `I2D_ASSERT_NEXT(a_conv_done, clk_i, rst_ni, conv_last, state_q == ST_SKIP)
  // Digit count stays nonzero while digits remain to be emitted.
  `I2D_ASSERT_IMP(a_ndig_live, clk_i, rst_ni, state_q == ST_SKIP || state_q == ST_EMIT, ndig_q != '0)
  // Emitted digits never start with a zero unless the value is zero.
  `I2D_ASSERT_IMP(a_no_lead_zero, clk_i, rst_ni, skip_done, top_digit != 4'd0 || ndig_q == NdigWidth'(1))

endmodule

[src/i2d_bcd_cell.sv]
// One BCD digit cell: clear, shift-and-add-3 step or digit shift toward the top.
module i2d_bcd_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  i2d_pkg::i2d_cell_ctrl_t ctrl_i,
  input  logic                   bit_i,
  input  logic [3:0]             digit_i,
  output logic                   carry_o,
  output logic [3:0]             digit_o
);
  import i2d_pkg::*;

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  // Add three when the digit is five or more, so the doubling carries correctly.
  assign adj     = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  // Next digit value.
  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = 4'd0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end
  end

  // Digit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

[sim/testbench.sv]
// Self-checking testbench for the signed 128-bit integer to decimal text converter.
module testbench;
  import i2d_pkg::*;

  localparam logic [127:0] DecimalBase = 128'd10;
  localparam int unsigned  CycleLimit  = 2_000_000;
  localparam int unsigned  DrainCycles = 200;

  // One character of the expected decimal text.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] value_high_i;
  logic [63:0] value_low_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  character_o;
  logic        is_last_o;

  text_char_t  text_q[$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit          no_idle;

  int128_to_decimal_text i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_high_i(value_high_i),
    .value_low_i (value_low_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .is_last_o   (is_last_o)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Works out the signed decimal text of one value and queues its characters.
  function automatic void predict_text(input logic [127:0] value);
    logic [127:0] magnitude;
    logic [7:0]   digits[$];
    text_char_t   entry;
    bit           negative;
    negative  = value[HalfWidth + SignBit];
    magnitude = negative ? -value : value;
    // Digits come out least significant first.
    do begin
      digits.push_front(CharZero + 8'(magnitude % DecimalBase));
      magnitude = magnitude / DecimalBase;
    end while (magnitude != '0);
    if (negative) begin
      entry.ch   = CharMinus;
      entry.last = 1'b0;
      text_q.push_back(entry);
    end
    foreach (digits[k]) begin
      entry.ch   = digits[k];
      entry.last = (k == digits.size() - 1);
      text_q.push_back(entry);
    end
  endfunction

  // Random value of mixed shape: full width, short positive or negative, near a power of ten.
  function automatic logic [127:0] random_value();
    logic [127:0] v;
    logic [127:0] power;
    int unsigned  width;
    v = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        width = $urandom_range(1, 127);
        v     = v & ((128'd1 << width) - 128'd1);
      end
      2: begin
        width = $urandom_range(1, 127);
        v     = -(v & ((128'd1 << width) - 128'd1));
      end
      default: begin
        power = 128'd1;
        repeat ($urandom_range(0, 38)) power = power * DecimalBase;
        v = power + 128'($urandom_range(0, 2)) - 128'd1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  // Sends one value; returns at the edge where the transfer takes place.
  task automatic send_value(input logic [127:0] value);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    value_high_i <= value[127:64];
    value_low_i  <= value[63:0];
    do @(posedge clk_i); while (in_stall_o);
    predict_text(value);
  endtask

  // Holds off until every queued character has arrived.
  task automatic drain_text();
    in_valid_i <= 1'b0;
    while (text_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Receiver: stalls a random number of cycles before each character transfer.
  initial begin : receiver
    int unsigned hold;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Checks each character transfer against the oldest expected character.
  always @(posedge clk_i) begin : text_checker
    text_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (text_q.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h", character_o));
      end else begin
        want = text_q.pop_front();
        if (character_o !== want.ch)
          report_mismatch($sformatf("character 0x%02h, expected 0x%02h", character_o, want.ch));
        if (is_last_o !== want.last)
          report_mismatch($sformatf("is_last %b, expected %b", is_last_o, want.last));
      end
    end
  end

  // Zero, the sign extremes, carries across the halves and power-of-ten boundaries.
  task automatic test_directed();
    logic [127:0] values[$];
    logic [127:0] p38;
    p38 = 128'd1;
    repeat (38) p38 = p38 * DecimalBase;
    values = '{128'd0, 128'd1, -128'd1, 128'd9, 128'd10, -128'd10,
               {1'b0, {127{1'b1}}}, {1'b1, 127'd0},
               {64'd0, {64{1'b1}}}, {{64{1'b1}}, 64'd0}, {64'd1, 64'd0},
               p38 - 128'd1, p38, -p38,
               {{32{2'b01}}, {32{2'b10}}}, {{32{2'b10}}, {32{2'b01}}}};
    foreach (values[k]) send_value(values[k]);
  endtask

  // Random values with random idling on both sides.
  task automatic test_random_values(input int unsigned count);
    repeat (count) send_value(random_value());
  endtask

  // Back-to-back transfers with no idling on either side.
  task automatic test_back_to_back(input int unsigned count);
    no_idle = 1'b1;
    repeat (count) send_value(random_value());
    no_idle = 1'b0;
  endtask

  // The sender waits for the whole text of the previous value before each transfer.
  task automatic test_drain_pause(input int unsigned count);
    repeat (count) begin
      drain_text();
      send_value(random_value());
    end
  endtask

  // Reset, the tests in turn, then drain and verdict.
  initial begin
    error_count  = 0;
    cycle_count  = 0;
    no_idle      = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    value_high_i = '0;
    value_low_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_values(160);
    test_back_to_back(40);
    test_drain_pause(8);
    test_random_values(180);

    in_valid_i <= 1'b0;
    while (text_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
